[rtl/sti_pkg.sv]
`default_nettype none
package sti_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 7;
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int POS_W  = 6;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		RD_PM1,
		RD_PM2,
		RD_MID
	} rd_sel_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_FULL,
		RES_INS,
		RES_HIT,
		RES_MISS
	} res_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_shift;
		logic    wr_new;
		logic    p_dec;
		logic    mid_ld;
		logic    lo_up;
		logic    hi_dn;
		res_t    res;
		logic    push;
	} sti_cmd_t;

	typedef struct packed {
		logic is_search;
		logic full;
		logic p_zero;
		logic p_one;
		logic key_gt;
		logic key_eq;
		logic lo_gt_hi;
		logic out_busy;
	} sti_stat_t;

endpackage
`default_nettype wire

[rtl/sti_req_if.sv]
`default_nettype none
interface sti_req_if;
	logic                            valid;
	logic                            ready;
	logic                            action;
	logic signed [sti_pkg::KEY_W-1:0] key;
	logic signed [sti_pkg::VAL_W-1:0] record_value;

	modport source (output valid, action, key, record_value, input ready);
	modport sink   (input valid, action, key, record_value, output ready);
endinterface
`default_nettype wire

[rtl/sti_rsp_if.sv]
`default_nettype none
interface sti_rsp_if;
	logic                             valid;
	logic                             ready;
	logic        [sti_pkg::STAT_W-1:0] status;
	logic        [sti_pkg::POS_W-1:0]  position;
	logic signed [sti_pkg::VAL_W-1:0]  found_value;

	modport source (output valid, status, position, found_value, input ready);
	modport sink   (input valid, status, position, found_value, output ready);
endinterface
`default_nettype wire

[rtl/sti_ram.sv]
`default_nettype none
module sti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/sti_ctrl.sv]
`default_nettype none
module sti_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output      logic               req_ready,
	input  wire sti_pkg::sti_stat_t stat,
	output      sti_pkg::sti_cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_INS_CMP,
		S_INS_PUT,
		S_SRCH_CHK,
		S_SRCH_CMP,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = sti_pkg::RD_PM1;
		cmd.res      = sti_pkg::RES_NONE;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (stat.is_search) begin
					state_d = S_SRCH_CHK;
				end else if (stat.full) begin
					cmd.res = sti_pkg::RES_FULL;
					state_d = S_EMIT;
				end else if (stat.p_zero) begin
					cmd.wr_new = 1'b1;
					cmd.res    = sti_pkg::RES_INS;
					state_d    = S_EMIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = sti_pkg::RD_PM1;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (stat.key_gt) begin
					// move the larger entry up, fetch the next one below
					cmd.wr_shift = 1'b1;
					cmd.p_dec    = 1'b1;
					if (stat.p_one) begin
						state_d = S_INS_PUT;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = sti_pkg::RD_PM2;
					end
				end else begin
					cmd.wr_new = 1'b1;
					cmd.res    = sti_pkg::RES_INS;
					state_d    = S_EMIT;
				end
			end
			S_INS_PUT: begin
				cmd.wr_new = 1'b1;
				cmd.res    = sti_pkg::RES_INS;
				state_d    = S_EMIT;
			end
			S_SRCH_CHK: begin
				if (stat.lo_gt_hi) begin
					cmd.res = sti_pkg::RES_MISS;
					state_d = S_EMIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = sti_pkg::RD_MID;
					cmd.mid_ld = 1'b1;
					state_d    = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (stat.key_eq) begin
					cmd.res = sti_pkg::RES_HIT;
					state_d = S_EMIT;
				end else begin
					cmd.lo_up = !stat.key_gt;
					cmd.hi_dn = stat.key_gt;
					state_d   = S_SRCH_CHK;
				end
			end
			S_EMIT: begin
				if (!stat.out_busy) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

[rtl/sti_dp.sv]
`default_nettype none
module sti_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [sti_pkg::CAP_W-1:0]        cfg_wdata,
	input  wire logic                             req_action,
	input  wire logic signed [sti_pkg::KEY_W-1:0] req_key,
	input  wire logic signed [sti_pkg::VAL_W-1:0] req_value,
	output      logic                             rsp_valid,
	input  wire logic                             rsp_ready,
	output      logic [sti_pkg::STAT_W-1:0]       rsp_status,
	output      logic [sti_pkg::POS_W-1:0]        rsp_position,
	output      logic signed [sti_pkg::VAL_W-1:0] rsp_value,
	input  wire sti_pkg::sti_cmd_t                cmd,
	output      sti_pkg::sti_stat_t               stat
);
	localparam int AW = sti_pkg::ADDR_W;
	localparam int CW = sti_pkg::CNT_W;

	logic                      act_q;
	logic [sti_pkg::KEY_W-1:0] key_q;
	logic [sti_pkg::VAL_W-1:0] val_q;
	logic [CW-1:0]             p_q;
	logic [CW-1:0]             count_q;
	logic [sti_pkg::CAP_W-1:0] cap_q;
	logic signed [CW:0]        lo_q;
	logic signed [CW:0]        hi_q;
	logic [AW-1:0]             mid_q;

	logic [sti_pkg::STAT_W-1:0] res_status_q;
	logic [sti_pkg::POS_W-1:0]  res_pos_q;
	logic [sti_pkg::VAL_W-1:0]  res_val_q;
	logic                       out_valid_q;
	logic [sti_pkg::STAT_W-1:0] out_status_q;
	logic [sti_pkg::POS_W-1:0]  out_pos_q;
	logic [sti_pkg::VAL_W-1:0]  out_val_q;

	logic [sti_pkg::KEY_W-1:0] rd_key;
	logic [sti_pkg::VAL_W-1:0] rd_val;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             wr_addr;
	logic                      wr_en;
	logic [sti_pkg::KEY_W-1:0] wr_key;
	logic [sti_pkg::VAL_W-1:0] wr_val;
	logic [CW:0]               mid_sum;
	logic [AW-1:0]             mid_c;
	logic [CW:0]               mid_ext;
	logic [sti_pkg::CMP_W-1:0] cap_ext;
	logic [sti_pkg::CMP_W-1:0] depth_ext;
	logic [sti_pkg::CMP_W-1:0] cap_eff;

	assign mid_sum = lo_q + hi_q;
	assign mid_c   = AW'(mid_sum >> 1);
	assign mid_ext = (CW + 1)'(mid_q);

	always_comb begin
		unique case (cmd.rd_sel)
			sti_pkg::RD_PM1: rd_addr = AW'(p_q - CW'(1));
			sti_pkg::RD_PM2: rd_addr = AW'(p_q - CW'(2));
			sti_pkg::RD_MID: rd_addr = mid_c;
			default:         rd_addr = mid_c;
		endcase
	end

	assign wr_en   = cmd.wr_shift | cmd.wr_new;
	assign wr_addr = AW'(p_q);
	assign wr_key  = cmd.wr_new ? key_q : rd_key;
	assign wr_val  = cmd.wr_new ? val_q : rd_val;

	sti_ram #(.WIDTH(sti_pkg::KEY_W), .DEPTH(sti_pkg::DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_key),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_key)
	);

	sti_ram #(.WIDTH(sti_pkg::VAL_W), .DEPTH(sti_pkg::DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_val),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_val)
	);

	assign cap_ext   = sti_pkg::CMP_W'(cap_q);
	assign depth_ext = sti_pkg::CMP_W'(sti_pkg::DEPTH);
	assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;

	assign stat.is_search = (act_q == sti_pkg::ACT_SEARCH);
	assign stat.full      = (sti_pkg::CMP_W'(count_q) >= cap_eff);
	assign stat.p_zero    = (p_q == '0);
	assign stat.p_one     = (p_q == CW'(1));
	assign stat.key_gt    = ($signed(rd_key) > $signed(key_q));
	assign stat.key_eq    = (rd_key == key_q);
	assign stat.lo_gt_hi  = (lo_q > hi_q);
	assign stat.out_busy  = out_valid_q & !rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= sti_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.wr_new) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= req_action;
			key_q <= req_key;
			val_q <= req_value;
			p_q   <= count_q;
			lo_q  <= '0;
			hi_q  <= $signed({1'b0, count_q}) - $signed((CW + 1)'(1));
		end else if (cmd.p_dec) begin
			p_q <= p_q - CW'(1);
		end
		if (cmd.mid_ld) begin
			mid_q <= mid_c;
		end
		if (cmd.lo_up) begin
			lo_q <= mid_ext + (CW + 1)'(1);
		end
		if (cmd.hi_dn) begin
			hi_q <= mid_ext - (CW + 1)'(1);
		end
		unique case (cmd.res)
			sti_pkg::RES_FULL: begin
				res_status_q <= sti_pkg::ST_FULL;
				res_pos_q    <= '0;
				res_val_q    <= '0;
			end
			sti_pkg::RES_INS: begin
				res_status_q <= sti_pkg::ST_OK;
				res_pos_q    <= sti_pkg::POS_W'(p_q);
				res_val_q    <= '0;
			end
			sti_pkg::RES_HIT: begin
				res_status_q <= sti_pkg::ST_OK;
				res_pos_q    <= sti_pkg::POS_W'(mid_q);
				res_val_q    <= rd_val;
			end
			sti_pkg::RES_MISS: begin
				res_status_q <= sti_pkg::ST_MISS;
				res_pos_q    <= '0;
				res_val_q    <= '0;
			end
			default: begin
			end
		endcase
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
			out_val_q    <= res_val_q;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign rsp_status   = out_status_q;
	assign rsp_position = out_pos_q;
	assign rsp_value    = $signed(out_val_q);
endmodule
`default_nettype wire

[rtl/sorted_table_insert_search_core.sv]
// Insert: the entries above the new key are shifted up one position at a time, one shift per cycle
//   on the single RAM write port; a refused insert (table full) or an insert into an empty table
//   needs no shift.
// Search: binary search, each probe a registered RAM read, then a compare; one item at a time,
//   the next item can be taken in the cycle after the previous result moves to the output register.
// Reset: count cleared, capacity back to 64, output empty; table contents stay unknown.
`default_nettype none
module sorted_table_insert_search_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sti_pkg::CAP_W-1:0]   cfg_wdata,
	sti_req_if.sink                          req,
	sti_rsp_if.source                        rsp
);
	// command and status between the sequencer and the datapath
	sti_pkg::sti_cmd_t  cmd;
	sti_pkg::sti_stat_t stat;

	// Sequencer: take one item, walk the insert shift or the search probes,
	// then hand the result to the output register once it is free.
	sti_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: key/value RAMs, count, capacity, search bounds, and the
	// output register that lets a finished result wait for its transfer
	// while the next item is accepted.
	sti_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_action   (req.action),
		.req_key      (req.key),
		.req_value    (req.record_value),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.rsp_status   (rsp.status),
		.rsp_position (rsp.position),
		.rsp_value    (rsp.found_value),
		.cmd          (cmd),
		.stat         (stat)
	);
endmodule
`default_nettype wire

[dv/tb_sorted_table_insert_search_core.sv]
`timescale 1ns / 100ps
module tb_sorted_table_insert_search_core;
	import sti_pkg::*;

	// Pacing: each side idles in about 12 percent of cycles. Transfers between
	// CALM_FROM and CALM_TO run with no idling at all.
	localparam int IDLE_PCT    = 12;
	localparam int CALM_FROM   = 300;
	localparam int CALM_TO     = 450;
	localparam int MAX_REPORTS = 10;
	// The slowest insert shifts every entry up. Allow many times its length with no transfer.
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_OPS   = 150;

	localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic [KEY_W-1:0] KEY_MAX = ~KEY_MIN;

	typedef struct packed {
		logic             act;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} table_op_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  found_value;
	} table_rsp_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	sti_req_if req_bus ();
	sti_rsp_if rsp_bus ();

	sorted_table_insert_search_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_bus),
		.rsp      (rsp_bus)
	);

	always #5 clk = ~clk;

	// Table shadow: sorted keys and values, fill count and the capacity
	// register as last written.
	logic signed [KEY_W-1:0] tbl_key [DEPTH];
	logic signed [VAL_W-1:0] tbl_val [DEPTH];
	int                      tbl_count = 0;
	int                      cap_limit = int'(CAP_RESET);

	table_op_t        op_queue [$];
	table_rsp_t       rsp_expected [$];
	logic [KEY_W-1:0] inserted_keys [$];

	int ops_sent     = 0;
	int rsps_seen    = 0;
	int mismatches   = 0;
	int stall_cycles = 0;

	function automatic bit pacing_on(input int count);
		return count < CALM_FROM || count >= CALM_TO;
	endfunction

	// Apply one operation to the shadow table and return the response it
	// should produce. Inserts land after any equal keys; searches follow the
	// same probe order as the block so duplicate hits agree.
	function automatic table_rsp_t apply_table_op(input table_op_t op);
		table_rsp_t              r;
		logic signed [KEY_W-1:0] k;
		int                      p;
		int                      lo;
		int                      hi;
		int                      mid;
		int                      room;
		r    = '0;
		k    = $signed(op.key);
		room = (cap_limit > DEPTH) ? DEPTH : cap_limit;
		if (op.act == ACT_INSERT) begin
			if (tbl_count >= room) begin
				r.status = ST_FULL;
			end else begin
				p = tbl_count;
				while (p > 0 && tbl_key[p-1] > k) begin
					tbl_key[p] = tbl_key[p-1];
					tbl_val[p] = tbl_val[p-1];
					p--;
				end
				tbl_key[p] = k;
				tbl_val[p] = $signed(op.val);
				tbl_count++;
				r.status   = ST_OK;
				r.position = POS_W'(p);
			end
		end else begin
			r.status = ST_MISS;
			lo = 0;
			hi = tbl_count - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (tbl_key[mid] == k) begin
					r.status      = ST_OK;
					r.position    = POS_W'(mid);
					r.found_value = tbl_val[mid];
					break;
				end else if (tbl_key[mid] < k) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
		end
		return r;
	endfunction

	// Keys: about a third from a small pool so duplicates and hits are common, some
	// range extremes, the rest (half) fully random.
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			case ($urandom_range(0, 7))
				0: return 32'hFFFF_FFF9;
				1: return 32'hFFFF_FFFF;
				2: return 32'h0000_0000;
				3: return 32'h0000_0001;
				4: return 32'h0000_0003;
				5: return 32'h0000_002A;
				6: return 32'hFFFE_7960;
				default: return 32'h0010_0000;
			endcase
		end else if (roll < 50) begin
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return KEY_MIN + 1;
				default: return KEY_MAX - 1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic queue_op(input logic act, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		table_op_t op;
		op.act = act;
		op.key = k;
		op.val = v;
		op_queue.push_back(op);
	endtask

	// Mix inserts and searches; searches often reuse keys already offered
	// for insert so hits reach deep into a well-filled table.
	task automatic queue_random_ops(input int n);
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 45) begin
				k = pick_key();
				inserted_keys.push_back(k);
				queue_op(ACT_INSERT, k, $urandom);
			end else begin
				if (inserted_keys.size() != 0 && $urandom_range(0, 99) < 45)
					k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
				else
					k = pick_key();
				queue_op(ACT_SEARCH, k, $urandom);
			end
		end
	endtask

	// Wait until every queued operation is taken and answered, then hold
	// while the block is idle. Check at the falling edge, clear of
	// updates made at the rising edge.
	task automatic drain_table();
		while (op_queue.size() != 0 || req_bus.valid || rsp_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CAP_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cap_limit = value;
	endtask

	// Request driver: on a transfer, predict the response from what is on the
	// bus; then present the next pending operation unless this cycle idles.
	always @(posedge clk) begin : op_driver
		table_op_t nxt;
		logic      nxt_valid;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			nxt_valid = req_bus.valid;
			if (req_bus.valid && req_bus.ready) begin
				nxt.act = req_bus.action;
				nxt.key = req_bus.key;
				nxt.val = req_bus.record_value;
				rsp_expected.push_back(apply_table_op(nxt));
				ops_sent++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && op_queue.size() != 0 &&
					!(pacing_on(ops_sent) && $urandom_range(0, 99) < IDLE_PCT)) begin
				nxt = op_queue.pop_front();
				req_bus.action       <= nxt.act;
				req_bus.key          <= nxt.key;
				req_bus.record_value <= nxt.val;
				nxt_valid = 1'b1;
			end
			req_bus.valid <= nxt_valid;
		end
	end

	// Response monitor: compare each transfer with the oldest prediction,
	// then choose ready for the next cycle.
	always @(posedge clk) begin : rsp_monitor
		table_rsp_t want;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				rsps_seen++;
				if (rsp_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: response with nothing outstanding: status %0d position %0d value %h",
							$realtime, rsp_bus.status, rsp_bus.position, rsp_bus.found_value);
				end else begin
					want = rsp_expected.pop_front();
					if (rsp_bus.status !== want.status || rsp_bus.position !== want.position ||
							rsp_bus.found_value !== want.found_value) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: mismatch (expected/actual) status %0d/%0d position %0d/%0d value %h/%h",
								$realtime, want.status, rsp_bus.status, want.position,
								rsp_bus.position, want.found_value, rsp_bus.found_value);
					end
				end
			end
			rsp_bus.ready <= !(pacing_on(rsps_seen) && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Watchdog: end the run when no transfer happens on either side for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int nxt_cap;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		req_bus.valid        = 1'b0;
		req_bus.action       = ACT_INSERT;
		req_bus.key          = '0;
		req_bus.record_value = '0;
		rsp_bus.ready        = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Capacity zero: every insert is refused, searches miss on the empty table.
		write_capacity(0);
		queue_op(ACT_SEARCH, KEY_MIN, $urandom);
		queue_op(ACT_INSERT, KEY_MAX, $urandom);
		queue_op(ACT_INSERT, 32'h0000_0000, 32'h8000_0000);
		drain_table();

		// Capacity one: the second insert finds the table full.
		write_capacity(1);
		queue_op(ACT_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
		queue_op(ACT_INSERT, 32'h0000_0005, $urandom);
		queue_op(ACT_SEARCH, 32'h0000_0000, $urandom);
		queue_op(ACT_SEARCH, 32'h0000_0001, $urandom);
		drain_table();

		// Capacity above the depth: key and value extremes, duplicates of zero.
		write_capacity(127);
		queue_op(ACT_INSERT, KEY_MAX, $urandom);
		queue_op(ACT_INSERT, KEY_MIN, $urandom);
		queue_op(ACT_INSERT, 32'hFFFF_FFFF, $urandom);
		queue_op(ACT_INSERT, 32'h0000_0000, $urandom);
		queue_op(ACT_INSERT, 32'h0000_0001, $urandom);
		queue_op(ACT_INSERT, 32'h0000_0000, $urandom);
		queue_op(ACT_INSERT, KEY_MAX - 1, 32'h0000_0000);
		queue_op(ACT_INSERT, KEY_MIN + 1, 32'hFFFF_FFFF);
		queue_op(ACT_SEARCH, KEY_MIN, $urandom);
		queue_op(ACT_SEARCH, KEY_MAX, $urandom);
		queue_op(ACT_SEARCH, 32'h0000_0000, $urandom);
		queue_op(ACT_SEARCH, 32'hFFFF_FFFF, $urandom);
		queue_op(ACT_SEARCH, 32'h0000_0002, $urandom);
		drain_table();

		// Random phases: grow the table in steps, try a capacity below the
		// current count, then fill to the depth and keep searching.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: nxt_cap = tbl_count + 12;
				1: nxt_cap = 3;
				2: nxt_cap = tbl_count + 15;
				3: nxt_cap = DEPTH;
				4: nxt_cap = 100;
				default: nxt_cap = 127;
			endcase
			write_capacity(nxt_cap);
			queue_random_ops(PHASE_OPS);
			drain_table();
		end

		// Hold long enough for a stray late response to show up.
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && rsp_expected.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
